FILE: design/assert_macros.svh
// Assertion macros shared by the curve plotter modules.
// No dependencies; included by each module that asserts.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under reset.
`define BCP_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication under reset.
`define BCP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: design/bcp_pkg.sv
// Shared types and constants of the curve plotter.
// No dependencies; imported by every module of the block.
package bcp_pkg;

   localparam int DEF_MAX_WIDTH   = 512;
   localparam int DEF_MAX_HEIGHT  = 512;
   localparam int DEF_CURVE_STEPS = 2000;

   localparam int COORD_W   = 16;
   localparam int DIM_W     = 13;
   localparam int CFG_IDX_W = 3;
   localparam int PIX_W     = 32;

   localparam logic [CFG_IDX_W-1:0] CSR_FRAME_WIDTH  = 3'd0;
   localparam logic [CFG_IDX_W-1:0] CSR_FRAME_HEIGHT = 3'd1;
   localparam logic [CFG_IDX_W-1:0] CSR_CONTRAST     = 3'd2;
   localparam logic [CFG_IDX_W-1:0] CSR_FADE         = 3'd3;
   localparam logic [CFG_IDX_W-1:0] CSR_CLIP_MODE    = 3'd4;

   localparam logic [9:0]       RST_FRAME_WIDTH  = 10'd400;
   localparam logic [9:0]       RST_FRAME_HEIGHT = 10'd400;
   localparam logic [PIX_W-1:0] RST_CONTRAST     = 32'd4287664168;
   localparam logic [PIX_W-1:0] RST_FADE         = 32'd84216335;

   typedef enum logic [1:0] {
      ACT_PLOT  = 2'd0,
      ACT_FADE  = 2'd1,
      ACT_CLEAR = 2'd2,
      ACT_READ  = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      OP_ADD  = 2'd0,
      OP_SUB  = 2'd1,
      OP_READ = 2'd2
   } mem_op_type;

   typedef struct packed {
      logic       valid;
      mem_op_type op;
   } mem_req_type;

   typedef struct packed {
      logic               valid;
      logic               last;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
   } point_type;

endpackage

FILE: design/bcp_bezier.sv
// Quadratic curve point generator: forward differences kept as quotient and
// remainder of the step count squared, set up by reciprocal multiplication. Uses bcp_pkg.
module bcp_bezier
   import bcp_pkg::*;
#(
   parameter int CURVE_STEPS = DEF_CURVE_STEPS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [COORD_W-1:0] start_x,
   input  logic [COORD_W-1:0] start_y,
   input  logic [COORD_W-1:0] end_x,
   input  logic [COORD_W-1:0] end_y,
   input  logic [COORD_W-1:0] ctrl_x,
   input  logic [COORD_W-1:0] ctrl_y,
   output point_type          pt
);
`include "assert_macros.svh"

   localparam int M  = CURVE_STEPS * CURVE_STEPS;
   localparam int RW = $clog2(M + 1);
   localparam int DW = $clog2(CURVE_STEPS) + 20;
   localparam int QW = 18;
   localparam int JW = $clog2(CURVE_STEPS + 1);
   localparam int PW = DW + 32;
   localparam longint unsigned RECIP = (64'd1 << 32) / M;

   typedef enum logic [2:0] {
      B_IDLE = 3'b001,
      B_DIV  = 3'b010,
      B_STEP = 3'b100
   } bstate_type;

   typedef struct packed {
      logic signed [QW-1:0] q;
      logic [RW-1:0]        r;
      logic signed [QW-1:0] dq;
      logic [RW-1:0]        dr;
      logic signed [QW-1:0] aq;
      logic [RW-1:0]        ar;
   } axis_type;

   bstate_type          bst_ff, bst_in;
   logic [1:0]          dcnt_ff, dcnt_in;
   logic [1:0]          phase_ff, phase_in;
   logic [JW-1:0]       j_ff, j_in;
   logic [COORD_W-1:0]  sx_ff, sy_ff, ex_ff, ey_ff, cx_ff, cy_ff;
   axis_type            ax_ff, ay_ff;
   logic [DW-1:0]       dvd_ff, quo_ff, rem_ff;
   logic                neg_ff;

   logic [DW-1:0]       hx, hy, d0x, d0y, opnd;
   logic [PW-1:0]       prod;
   logic                ge;
   logic [DW-1:0]       quo_fix, rem_fix;
   logic [RW-1:0]       fr;
   logic signed [QW-1:0] qa, fq;

   function automatic axis_type step_axis(input axis_type a);
      axis_type    n;
      logic [RW:0] rs, ds;
      logic        c1, c2;
      n  = a;
      rs = {1'b0, a.r} + {1'b0, a.dr};
      c1 = (rs >= (RW+1)'(M));
      n.r = c1 ? RW'(rs - (RW+1)'(M)) : RW'(rs);
      n.q = a.q + a.dq + QW'(c1);
      ds = {1'b0, a.dr} + {1'b0, a.ar};
      c2 = (ds >= (RW+1)'(M));
      n.dr = c2 ? RW'(ds - (RW+1)'(M)) : RW'(ds);
      n.dq = a.dq + a.aq + QW'(c2);
      return n;
   endfunction

   // second difference term s - 2c + e, first difference 2N(c - s) + h
   always_comb begin
      hx  = DW'(sx_ff) + DW'(ex_ff) - (DW'(cx_ff) << 1);
      hy  = DW'(sy_ff) + DW'(ey_ff) - (DW'(cy_ff) << 1);
      d0x = (DW'(cx_ff) - DW'(sx_ff)) * DW'(2 * CURVE_STEPS) + hx;
      d0y = (DW'(cy_ff) - DW'(sy_ff)) * DW'(2 * CURVE_STEPS) + hy;
      case (phase_ff)
         2'd0:    opnd = d0x;
         2'd1:    opnd = hx << 1;
         2'd2:    opnd = d0y;
         default: opnd = hy << 1;
      endcase
   end

   // estimate falls at most one short; one compare and subtract settles it
   always_comb begin
      prod    = PW'(dvd_ff) * PW'(RECIP);
      ge      = (rem_ff >= DW'(M));
      quo_fix = ge ? quo_ff + DW'(1) : quo_ff;
      rem_fix = ge ? rem_ff - DW'(M) : rem_ff;
      qa      = QW'(quo_fix);
      if (!neg_ff) begin
         fq = qa;
         fr = RW'(rem_fix);
      end else if (rem_fix == '0) begin
         fq = -qa;
         fr = '0;
      end else begin
         fq = -qa - QW'(1);
         fr = RW'(DW'(M) - rem_fix);
      end
   end

   always_comb begin
      bst_in   = bst_ff;
      dcnt_in  = dcnt_ff;
      phase_in = phase_ff;
      j_in     = j_ff;
      case (bst_ff)
         B_IDLE: begin
            if (start) begin
               bst_in   = B_DIV;
               dcnt_in  = '0;
               phase_in = '0;
            end
         end
         B_DIV: begin
            dcnt_in = dcnt_ff + 2'd1;
            if (dcnt_ff == 2'd3) begin
               phase_in = phase_ff + 2'd1;
               if (phase_ff == 2'd3) begin
                  bst_in = B_STEP;
                  j_in   = '0;
               end
            end
         end
         B_STEP: begin
            j_in = j_ff + JW'(1);
            if (j_ff == JW'(CURVE_STEPS)) bst_in = B_IDLE;
         end
         default: bst_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bst_ff   <= B_IDLE;
         dcnt_ff  <= '0;
         phase_ff <= '0;
         j_ff     <= '0;
      end else begin
         bst_ff   <= bst_in;
         dcnt_ff  <= dcnt_in;
         phase_ff <= phase_in;
         j_ff     <= j_in;
      end
   end

   always_ff @(posedge clock) begin
      if (bst_ff == B_IDLE && start) begin
         sx_ff <= start_x;  sy_ff <= start_y;
         ex_ff <= end_x;    ey_ff <= end_y;
         cx_ff <= ctrl_x;   cy_ff <= ctrl_y;
         ax_ff.q <= QW'(start_x);
         ax_ff.r <= '0;
         ay_ff.q <= QW'(start_y);
         ay_ff.r <= '0;
      end else if (bst_ff == B_DIV) begin
         case (dcnt_ff)
            2'd0: begin
               neg_ff <= opnd[DW-1];
               dvd_ff <= opnd[DW-1] ? -opnd : opnd;
            end
            2'd1:    quo_ff <= prod[PW-1:32];
            2'd2:    rem_ff <= dvd_ff - quo_ff * DW'(M);
            default: begin
               case (phase_ff)
                  2'd0:    begin ax_ff.dq <= fq; ax_ff.dr <= fr; end
                  2'd1:    begin ax_ff.aq <= fq; ax_ff.ar <= fr; end
                  2'd2:    begin ay_ff.dq <= fq; ay_ff.dr <= fr; end
                  default: begin ay_ff.aq <= fq; ay_ff.ar <= fr; end
               endcase
            end
         endcase
      end else if (bst_ff == B_STEP) begin
         ax_ff <= step_axis(ax_ff);
         ay_ff <= step_axis(ay_ff);
      end
   end

   assign pt.valid = (bst_ff == B_STEP);
   assign pt.last  = (bst_ff == B_STEP) && (j_ff == JW'(CURVE_STEPS));
   assign pt.x     = ax_ff.q[COORD_W-1:0];
   assign pt.y     = ay_ff.q[COORD_W-1:0];

   `BCP_ASSERT_IMPL(a_start_idle, clock, reset, start, bst_ff == B_IDLE,
      "curve start while generator busy")
   `BCP_ASSERT_IMPL(a_point_bound, clock, reset, pt.valid, j_ff <= JW'(CURVE_STEPS),
      "curve step count past the last point")
   `BCP_ASSERT_NEXT(a_last_idle, clock, reset, pt.last, bst_ff == B_IDLE,
      "generator did not stop after the last point")

endmodule

FILE: design/bcp_frame_mem.sv
// Frame store with a registered read-modify-write pipe and write forwarding.
// Uses bcp_pkg for request and op types.
module bcp_frame_mem
   import bcp_pkg::*;
#(
   parameter int DEPTH = DEF_MAX_WIDTH * DEF_MAX_HEIGHT,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             reset,
   input  mem_req_type      req,
   input  logic [AW-1:0]    req_addr,
   input  logic             clr_we,
   input  logic [AW-1:0]    clr_addr,
   input  logic [PIX_W-1:0] contrast,
   input  logic [PIX_W-1:0] fade,
   output logic             rd_valid,
   output logic [PIX_W-1:0] rd_data
);
`include "assert_macros.svh"

   logic [PIX_W-1:0] store_ff [DEPTH];
   logic [PIX_W-1:0] rdata_ff;
   mem_req_type      s1_ff;
   logic [AW-1:0]    s1_addr_ff;
   logic             pw_valid_ff;
   logic [AW-1:0]    pw_addr_ff;
   logic [PIX_W-1:0] pw_data_ff;

   logic [PIX_W-1:0] old_px, new_px, wdata;
   logic [AW-1:0]    waddr;
   logic             s1_we, we;

   function automatic logic [PIX_W-1:0] sat_add(input logic [PIX_W-1:0] a,
                                                input logic [PIX_W-1:0] b);
      logic [PIX_W-1:0] r;
      logic [8:0]       s;
      for (int i = 0; i < 4; i++) begin
         s = {1'b0, a[8*i +: 8]} + {1'b0, b[8*i +: 8]};
         r[8*i +: 8] = s[8] ? 8'hFF : s[7:0];
      end
      return r;
   endfunction

   function automatic logic [PIX_W-1:0] floor_sub(input logic [PIX_W-1:0] a,
                                                  input logic [PIX_W-1:0] b);
      logic [PIX_W-1:0] r;
      for (int i = 0; i < 4; i++)
         r[8*i +: 8] = (a[8*i +: 8] > b[8*i +: 8]) ? a[8*i +: 8] - b[8*i +: 8] : 8'h00;
      return r;
   endfunction

   // forward the word written last cycle; the array read saw the old one
   always_comb begin
      old_px = (pw_valid_ff && pw_addr_ff == s1_addr_ff) ? pw_data_ff : rdata_ff;
      case (s1_ff.op)
         OP_ADD:  new_px = sat_add(old_px, contrast);
         OP_SUB:  new_px = floor_sub(old_px, fade);
         default: new_px = old_px;
      endcase
      s1_we = s1_ff.valid && (s1_ff.op == OP_ADD || s1_ff.op == OP_SUB);
      we    = clr_we || s1_we;
      waddr = clr_we ? clr_addr : s1_addr_ff;
      wdata = clr_we ? '0 : new_px;
   end

   always_ff @(posedge clock) begin
      rdata_ff <= store_ff[req_addr];
      if (we) store_ff[waddr] <= wdata;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff       <= '0;
         pw_valid_ff <= 1'b0;
      end else begin
         s1_ff       <= req;
         pw_valid_ff <= we;
      end
      s1_addr_ff <= req_addr;
      pw_addr_ff <= waddr;
      pw_data_ff <= wdata;
   end

   assign rd_valid = s1_ff.valid && (s1_ff.op == OP_READ);
   assign rd_data  = old_px;

   `BCP_ASSERT_IMPL(a_clr_no_rmw, clock, reset, clr_we, !s1_ff.valid,
      "clear write collides with pipe write")
   `BCP_ASSERT_NEXT(a_req_then_no_clr, clock, reset, req.valid, !clr_we,
      "clear starts while pipe busy")

endmodule

FILE: design/bezier_curve_plotter_with_fade_top.sv
// Top level of the curve plotter: control sequencer, config registers,
// result register. Uses bcp_pkg, bcp_bezier and bcp_frame_mem.
//
//   channel | ports                         | transfer when
//   req     | req_valid/req_stall + fields  | req_valid & !req_stall
//   rsp     | rsp_valid/rsp_stall, pixel    | rsp_valid & !rsp_stall
//   csr     | csr_valid/csr_ready, idx/data | csr_valid & csr_ready
//
// Plot: forward-difference setup, then CURVE_STEPS+1 points, one point into the
//   read-modify-write pipe each cycle unless clipping drops it; a degenerate curve plots none.
// Fade: each active pixel in turn; clear: all MAX_WIDTH*MAX_HEIGHT words of the frame store.
// Read: zero outside the frame, else the pixel through the frame store read port.
// After reset a clearing pass over all MAX_WIDTH*MAX_HEIGHT words runs before the
//   first item; config writes are taken throughout. rsp_stall holds the result.
module bezier_curve_plotter_with_fade_top
   import bcp_pkg::*;
#(
   parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT  = DEF_MAX_HEIGHT,
   parameter int CURVE_STEPS = DEF_CURVE_STEPS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [1:0]           req_action,
   input  logic [COORD_W-1:0]   req_start_x,
   input  logic [COORD_W-1:0]   req_start_y,
   input  logic [COORD_W-1:0]   req_end_x,
   input  logic [COORD_W-1:0]   req_end_y,
   input  logic [COORD_W-1:0]   req_ctrl_x,
   input  logic [COORD_W-1:0]   req_ctrl_y,
   input  logic [8:0]           req_read_x,
   input  logic [8:0]           req_read_y,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [PIX_W-1:0]     rsp_pixel_rgba,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CFG_IDX_W-1:0] csr_index,
   input  logic [PIX_W-1:0]     csr_wdata
);
`include "assert_macros.svh"

   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = $clog2(DEPTH);

   typedef enum logic [5:0] {
      S_SWEEP     = 6'b000001,
      S_IDLE      = 6'b000010,
      S_CURVE     = 6'b000100,
      S_FADE      = 6'b001000,
      S_READ      = 6'b010000,
      S_READ_WAIT = 6'b100000
   } state_type;

   state_type        state_ff, state_in;
   logic [AW-1:0]    sweep_ff, sweep_in;
   logic [DIM_W-1:0] fx_ff, fx_in, fy_ff, fy_in;
   logic [8:0]       rx_ff, rx_in, ry_ff, ry_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [PIX_W-1:0] rsp_pix_ff, rsp_pix_in;

   logic [9:0]       fw_ff, fh_ff;
   logic [PIX_W-1:0] contrast_ff, fade_ff;
   logic             clip_ff;

   logic [DIM_W-1:0] aw, ah, cx_sel, cy_sel;
   logic             accept, degenerate, bez_start, slot_free, read_out;
   logic             out_x, out_y, keep;
   point_type        pt;
   mem_req_type      mreq;
   logic [AW-1:0]    maddr;
   logic             clr_we, rd_valid;
   logic [PIX_W-1:0] rd_data;

   function automatic logic [AW-1:0] pix_addr(input logic [DIM_W-1:0] x,
                                              input logic [DIM_W-1:0] y);
      return AW'(y) * AW'(MAX_WIDTH) + AW'(x);
   endfunction

   always_comb begin
      if (fw_ff == '0)                        aw = DIM_W'(1);
      else if (DIM_W'(fw_ff) > DIM_W'(MAX_WIDTH)) aw = DIM_W'(MAX_WIDTH);
      else                                    aw = DIM_W'(fw_ff);
      if (fh_ff == '0)                         ah = DIM_W'(1);
      else if (DIM_W'(fh_ff) > DIM_W'(MAX_HEIGHT)) ah = DIM_W'(MAX_HEIGHT);
      else                                     ah = DIM_W'(fh_ff);
   end

   assign accept     = req_valid && !req_stall;
   assign degenerate = (req_start_x == req_end_x) && (req_start_y == req_end_y);
   assign bez_start  = accept && (req_action == ACT_PLOT) && !degenerate;
   assign slot_free  = !rsp_valid_ff || !rsp_stall;
   assign read_out   = (DIM_W'(rx_ff) >= aw) || (DIM_W'(ry_ff) >= ah);

   // clamp to the frame edge, or drop when discarding
   always_comb begin
      out_x  = ({1'b0, pt.x} >= (COORD_W+1)'(aw));
      out_y  = ({1'b0, pt.y} >= (COORD_W+1)'(ah));
      keep   = !(clip_ff && (out_x || out_y));
      cx_sel = out_x ? aw - DIM_W'(1) : DIM_W'(pt.x);
      cy_sel = out_y ? ah - DIM_W'(1) : DIM_W'(pt.y);
   end

   always_comb begin
      state_in     = state_ff;
      sweep_in     = sweep_ff;
      fx_in        = fx_ff;
      fy_in        = fy_ff;
      rx_in        = rx_ff;
      ry_in        = ry_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_pix_in   = rsp_pix_ff;
      mreq.valid   = 1'b0;
      mreq.op      = OP_ADD;
      maddr        = pix_addr(cx_sel, cy_sel);
      clr_we       = 1'b0;
      case (state_ff)
         S_SWEEP: begin
            clr_we   = 1'b1;
            sweep_in = sweep_ff + AW'(1);
            if (sweep_ff == AW'(DEPTH - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (accept) begin
               case (req_action)
                  ACT_PLOT: if (!degenerate) state_in = S_CURVE;
                  ACT_FADE: begin
                     fx_in = '0;
                     fy_in = '0;
                     if (fade_ff[23:0] != '0) state_in = S_FADE;
                  end
                  ACT_CLEAR: begin
                     sweep_in = '0;
                     state_in = S_SWEEP;
                  end
                  default: begin
                     rx_in    = req_read_x;
                     ry_in    = req_read_y;
                     state_in = S_READ;
                  end
               endcase
            end
         end
         S_CURVE: begin
            mreq.valid = pt.valid && keep;
            mreq.op    = OP_ADD;
            if (pt.valid && pt.last) state_in = S_IDLE;
         end
         S_FADE: begin
            mreq.valid = 1'b1;
            mreq.op    = OP_SUB;
            maddr      = pix_addr(fx_ff, fy_ff);
            if (fx_ff == aw - DIM_W'(1)) begin
               fx_in = '0;
               fy_in = fy_ff + DIM_W'(1);
               if (fy_ff == ah - DIM_W'(1)) state_in = S_IDLE;
            end else begin
               fx_in = fx_ff + DIM_W'(1);
            end
         end
         S_READ: begin
            maddr = pix_addr(DIM_W'(rx_ff), DIM_W'(ry_ff));
            if (slot_free) begin
               if (read_out) begin
                  rsp_valid_in = 1'b1;
                  rsp_pix_in   = '0;
                  state_in     = S_IDLE;
               end else begin
                  mreq.valid = 1'b1;
                  mreq.op    = OP_READ;
                  state_in   = S_READ_WAIT;
               end
            end
         end
         S_READ_WAIT: begin
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
      if (rd_valid) begin
         rsp_valid_in = 1'b1;
         rsp_pix_in   = rd_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_SWEEP;
         sweep_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         fw_ff        <= RST_FRAME_WIDTH;
         fh_ff        <= RST_FRAME_HEIGHT;
         contrast_ff  <= RST_CONTRAST;
         fade_ff      <= RST_FADE;
         clip_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            case (csr_index)
               CSR_FRAME_WIDTH:  fw_ff       <= csr_wdata[9:0];
               CSR_FRAME_HEIGHT: fh_ff       <= csr_wdata[9:0];
               CSR_CONTRAST:     contrast_ff <= csr_wdata;
               CSR_FADE:         fade_ff     <= csr_wdata;
               CSR_CLIP_MODE:    clip_ff     <= csr_wdata[0];
               default:          ;
            endcase
         end
      end
      fx_ff      <= fx_in;
      fy_ff      <= fy_in;
      rx_ff      <= rx_in;
      ry_ff      <= ry_in;
      rsp_pix_ff <= rsp_pix_in;
   end

   bcp_bezier #(
      .CURVE_STEPS (CURVE_STEPS)
   ) u_bezier (
      .clock   (clock),
      .reset   (reset),
      .start   (bez_start),
      .start_x (req_start_x),
      .start_y (req_start_y),
      .end_x   (req_end_x),
      .end_y   (req_end_y),
      .ctrl_x  (req_ctrl_x),
      .ctrl_y  (req_ctrl_y),
      .pt      (pt)
   );

   bcp_frame_mem #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_frame_mem (
      .clock    (clock),
      .reset    (reset),
      .req      (mreq),
      .req_addr (maddr),
      .clr_we   (clr_we),
      .clr_addr (sweep_ff),
      .contrast (contrast_ff),
      .fade     (fade_ff),
      .rd_valid (rd_valid),
      .rd_data  (rd_data)
   );

   assign req_stall      = (state_ff != S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pixel_rgba = rsp_pix_ff;
   assign csr_ready      = 1'b1;

   `BCP_ASSERT_IMPL(a_rd_slot_free, clock, reset, state_ff == S_READ_WAIT, !rsp_valid_ff,
      "read data returns into a full result register")
   `BCP_ASSERT_IMPL(a_pt_in_curve, clock, reset, pt.valid, state_ff == S_CURVE,
      "curve point outside curve state")
   `BCP_ASSERT_NEXT(a_last_to_idle, clock, reset, pt.valid && pt.last, state_ff == S_IDLE,
      "sequencer missed last curve point")

endmodule
